// File: rtl/dtwr_pkg.sv
// Package for the ranging initiator core: payload structs, action codes, constants.
// Used by every module in rtl/.
`timescale 1ns / 1ps
package dtwr_pkg;
    localparam int RESPONDER_COUNT = 5;
    localparam int SLOT_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 40;
    localparam int CFG_DELAY_IDX = 5;

    typedef enum logic [2:0] {
        ACT_POLL   = 3'd0,
        ACT_RESET  = 3'd1,
        ACT_RANGE  = 3'd2,
        ACT_RESULT = 3'd3,
        ACT_LISTEN = 3'd4
    } action_t;

    typedef struct packed {
        logic        frame_good;
        logic [7:0]  source_id;
        logic [31:0] carried_reply_time;
        logic [39:0] receive_stamp;
        logic [39:0] transmit_stamp;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  sequence_number;
        logic [31:0] delayed_send_time;
        logic [2:0]  responder_slot;
        logic [63:0] flight_ticks;
        logic        flight_valid;
        logic        last_result;
    } out_item_t;

    // Command from front to back: what the accepted transaction asks for
    typedef enum logic [1:0] {
        CMD_ACK   = 2'd0,
        CMD_FINAL = 2'd1,
        CMD_BAD   = 2'd2,
        CMD_TOUT  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        poll;
        logic [31:0] carried;
        logic [39:0] rx;
        logic [39:0] tx;
    } cmd_t;
endpackage

// File: rtl/ds_twr_multi_initiator_core.sv
// Top level of the ranging initiator core: config registers, front, queue, back.
// Depends on dtwr_pkg, dtwr_front, dtwr_fifo, dtwr_back.
//
// Usage: each input transaction on in_valid/in_ready is one reception outcome.
// Each produces one to six result transactions on out_valid/out_ready; the
// final one of an input carries last_result. The first result is always a
// poll or listen action, optionally followed by reset, range-delayed, or the
// five range results of a completed round.
// The first result of an input passes through the command queue, the back
// end's command latch and its output register. The frame that closes a round
// runs five 64-bit divisions on one radix-2 divider, each after setup,
// multiply and denominator steps and followed by its emit; other inputs
// occupy the back end only for their first and second result states.
// A two-entry command queue lets the front accept while the back works.
// Reset clears the round state to the ack phase at slot 0, the frame
// sequence to zero, and the config registers to zero. A stalled receiver
// holds the current result; the back end waits and the queue fills, after
// which in_ready drops. Config writes (cfg_we, cfg_index, cfg_data) take
// effect at once and belong only to idle periods.
`timescale 1ns / 1ps
module ds_twr_multi_initiator_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  dtwr_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output dtwr_pkg::out_item_t                  out_data,
    input  logic                                 cfg_we,
    input  logic [dtwr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dtwr_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import dtwr_pkg::*;

    logic [7:0]  exp_id_reg [RESPONDER_COUNT];
    logic [39:0] delay_reg;
    logic        f_valid, f_ready, b_valid, b_ready;
    cmd_t        f_cmd, b_cmd;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < RESPONDER_COUNT; k++)
                exp_id_reg[k] <= '0;
            delay_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (32'(cfg_index) < RESPONDER_COUNT)
                exp_id_reg[cfg_index] <= cfg_data[7:0];
            else if (32'(cfg_index) == CFG_DELAY_IDX)
                delay_reg <= cfg_data;
        end
    end

    dtwr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .exp_id   (exp_id_reg),
        .cmd_valid(f_valid),
        .cmd_ready(f_ready),
        .cmd      (f_cmd)
    );

    dtwr_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_valid(f_valid),
        .wr_ready(f_ready),
        .wr_data (f_cmd),
        .rd_valid(b_valid),
        .rd_ready(b_ready),
        .rd_data (b_cmd)
    );

    dtwr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(b_valid),
        .cmd_ready(b_ready),
        .cmd      (b_cmd),
        .delay    (delay_reg),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );
endmodule

// File: rtl/dtwr_front.sv
// Front end: accepts input transactions, tracks round phase, classifies each frame.
// Depends on dtwr_pkg.
`timescale 1ns / 1ps
module dtwr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dtwr_pkg::in_item_t in_data,
    input  logic [7:0]        exp_id [dtwr_pkg::RESPONDER_COUNT],
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output dtwr_pkg::cmd_t    cmd
);
    import dtwr_pkg::*;

    logic              acks_reg, acks_next;
    logic              finals_reg, finals_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    cmd_t              cmd_c;
    logic              acks_eff;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;
    assign cmd       = cmd_c;

    // Classify the frame and advance the phase state
    always_comb
    begin
        acks_next   = acks_reg;
        finals_next = finals_reg;
        slot_next   = slot_reg;
        cmd_c.poll  = !acks_reg && !finals_reg && (slot_reg == '0);
        acks_eff    = acks_reg || cmd_c.poll;
        cmd_c.carried = in_data.carried_reply_time;
        cmd_c.rx    = in_data.receive_stamp;
        cmd_c.tx    = in_data.transmit_stamp;
        cmd_c.kind  = CMD_BAD;
        if (cmd_c.poll)
            acks_next = 1'b1;
        if (!in_data.frame_good)
        begin
            cmd_c.kind  = CMD_TOUT;
            acks_next   = 1'b0;
            finals_next = 1'b0;
            slot_next   = '0;
        end
        else if (32'(slot_reg) >= RESPONDER_COUNT ||
                 in_data.source_id != exp_id[slot_reg[SLOT_W-1:0]])
        begin
            acks_next   = 1'b0;
            finals_next = 1'b0;
            slot_next   = '0;
        end
        else
        begin
            cmd_c.kind = acks_eff ? CMD_ACK : CMD_FINAL;
            slot_next  = slot_reg + 1'b1;
            if (32'(slot_next) == RESPONDER_COUNT)
            begin
                slot_next = '0;
                if (acks_eff)
                begin
                    acks_next   = 1'b0;
                    finals_next = 1'b1;
                end
                else if (finals_reg)
                begin
                    acks_next   = 1'b0;
                    finals_next = 1'b0;
                end
                else
                    slot_next = SLOT_W'(RESPONDER_COUNT);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acks_reg   <= 1'b1;
            finals_reg <= 1'b0;
            slot_reg   <= '0;
        end
        else if (in_valid && in_ready)
        begin
            acks_reg   <= acks_next;
            finals_reg <= finals_next;
            slot_reg   <= slot_next;
        end
    end

    // The two phases never run together
    assert property (@(posedge clk) disable iff (!rst_n) !(acks_reg && finals_reg))
        else $error("ack and final phase both active");
    assert property (@(posedge clk) disable iff (!rst_n)
        finals_reg |-> 32'(slot_reg) < RESPONDER_COUNT)
        else $error("slot counter out of range in final phase");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_data.frame_good) |=> (slot_reg == '0 && !finals_reg))
        else $error("timeout did not clear the round");
endmodule

// File: rtl/dtwr_fifo.sv
// Two-entry command queue between the front end and the execution back end.
// Depends on dtwr_pkg.
`timescale 1ns / 1ps
module dtwr_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  dtwr_pkg::cmd_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output dtwr_pkg::cmd_t rd_data
);
    import dtwr_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];

    // Store on push
    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready)
            mem_reg[wp_reg] <= wr_data;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_valid && wr_ready)
                wp_reg <= !wp_reg;
            if (rd_valid && rd_ready)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
        end
    end
endmodule

// File: rtl/dtwr_div.sv
// Radix-2 restoring divider, 64 by 64 bits, one quotient bit per cycle.
// Depends on dtwr_pkg only for the import convention.
`timescale 1ns / 1ps
module dtwr_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        busy,
    output logic        done,
    output logic [63:0] quot
);
    import dtwr_pkg::*;

    logic [63:0] q_reg, d_reg;
    logic [64:0] r_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [64:0] r_shift;
    logic [65:0] diff;

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;
    assign r_shift = {r_reg[63:0], q_reg[63]};
    assign diff = {1'b0, r_shift} - {2'b0, d_reg};

    // Shift in one dividend bit and subtract when it fits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            d_reg <= den;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!diff[65])
            begin
                r_reg <= diff[64:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= r_shift;
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end
endmodule

// File: rtl/dtwr_back.sv
// Back end: carries out classified commands, holds ranging stores, emits result items.
// Depends on dtwr_pkg and dtwr_div.
`timescale 1ns / 1ps
module dtwr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  dtwr_pkg::cmd_t       cmd,
    input  logic [39:0]          delay,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dtwr_pkg::out_item_t  out_data
);
    import dtwr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FIRST, S_SECOND, S_SETUP, S_MUL1, S_MUL2, S_DEN,
        S_DIV, S_WAITDIV, S_EMIT
    } state_t;

    state_t            state_reg;
    cmd_t              cmd_reg;
    out_item_t         out_reg;
    logic              ov_reg;
    logic [7:0]        seq_reg;
    logic [63:0]       pss_reg;
    logic [63:0]       r1_mem [RESPONDER_COUNT];
    logic [31:0]       p1_mem [RESPONDER_COUNT];
    logic [31:0]       r2_mem [RESPONDER_COUNT];
    logic [SLOT_W-1:0] wslot_reg, i_reg;
    logic [63:0]       r1_reg, r2_reg, p1_reg, p2_reg, m1_reg, m2_reg, den_reg;
    logic [63:0]       txs_reg;
    logic              div_start, div_busy, div_done;
    logic [63:0]       div_q;
    logic [63:0]       sum40;
    logic              can_emit;
    logic              emit_c;
    out_item_t         res_c;

    assign cmd_ready = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = out_reg;
    assign div_start = (state_reg == S_DIV);
    assign sum40     = 64'(cmd_reg.rx) + 64'(delay);
    assign can_emit  = !ov_reg || out_ready;

    dtwr_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (m1_reg - m2_reg),
        .den  (den_reg),
        .busy (div_busy),
        .done (div_done),
        .quot (div_q)
    );

    // Build the result transaction for the current state
    always_comb
    begin
        emit_c = 1'b0;
        res_c  = '0;
        case (state_reg)
            S_FIRST:
            begin
                emit_c = 1'b1;
                res_c.action = cmd_reg.poll ? ACT_POLL : ACT_LISTEN;
                res_c.sequence_number = cmd_reg.poll ? seq_reg : 8'd0;
                res_c.last_result = (cmd_reg.kind == CMD_BAD) ||
                    (cmd_reg.kind != CMD_TOUT &&
                     !(32'(wslot_reg) == RESPONDER_COUNT - 1));
            end
            S_SECOND:
            begin
                emit_c = (cmd_reg.kind != CMD_FINAL);
                res_c.sequence_number = seq_reg;
                res_c.last_result = 1'b1;
                res_c.action = (cmd_reg.kind == CMD_TOUT) ? ACT_RESET : ACT_RANGE;
                if (cmd_reg.kind == CMD_ACK)
                    res_c.delayed_send_time = sum40[39:8];
            end
            S_EMIT:
            begin
                emit_c = 1'b1;
                res_c.action = ACT_RESULT;
                res_c.sequence_number = seq_reg;
                res_c.responder_slot = i_reg;
                res_c.flight_valid = den_reg != '0;
                res_c.flight_ticks = (den_reg != '0) ? div_q : 64'd0;
                res_c.last_result = 32'(i_reg) == RESPONDER_COUNT - 1;
            end
            default:
                emit_c = 1'b0;
        endcase
    end

    // Sequence the command: first result, a second result where one is due, then the division loop for a closing round
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            seq_reg   <= '0;
            wslot_reg <= '0;
            i_reg     <= '0;
        end
        else
        begin
            ov_reg <= (emit_c && can_emit) || (ov_reg && !out_ready);
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                        state_reg <= S_FIRST;
                end
                S_FIRST:
                begin
                    if (can_emit)
                    begin
                        if (cmd_reg.kind == CMD_BAD)
                        begin
                            wslot_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else if ((cmd_reg.kind == CMD_ACK || cmd_reg.kind == CMD_FINAL) &&
                                 32'(wslot_reg) != RESPONDER_COUNT - 1)
                        begin
                            wslot_reg <= wslot_reg + 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                            state_reg <= S_SECOND;
                    end
                end
                S_SECOND:
                begin
                    if (can_emit)
                    begin
                        if (cmd_reg.kind == CMD_FINAL)
                        begin
                            i_reg     <= '0;
                            state_reg <= S_SETUP;
                        end
                        else
                        begin
                            wslot_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_SETUP:
                    state_reg <= S_MUL1;
                S_MUL1:
                    state_reg <= S_MUL2;
                S_MUL2:
                    state_reg <= S_DEN;
                S_DEN:
                    state_reg <= S_DIV;
                S_DIV:
                    state_reg <= S_WAITDIV;
                S_WAITDIV:
                begin
                    if (div_done)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (can_emit)
                    begin
                        if (32'(i_reg) == RESPONDER_COUNT - 1)
                        begin
                            seq_reg   <= seq_reg + 1'b1;
                            wslot_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_SETUP;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Latch the command, hold the stores and run the datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
            cmd_reg <= cmd;
        if (emit_c && can_emit)
            out_reg <= res_c;
        case (state_reg)
            S_FIRST:
            begin
                if (can_emit)
                begin
                    if (cmd_reg.kind == CMD_ACK)
                    begin
                        r1_mem[wslot_reg] <= 64'(cmd_reg.rx) - 64'(cmd_reg.tx);
                        p1_mem[wslot_reg] <= cmd_reg.carried;
                        pss_reg <= 64'(cmd_reg.tx);
                    end
                    else if (cmd_reg.kind == CMD_FINAL)
                        r2_mem[wslot_reg] <= cmd_reg.carried;
                end
            end
            S_SECOND:
            begin
                if (can_emit && cmd_reg.kind == CMD_FINAL)
                    txs_reg <= 64'(cmd_reg.tx);
            end
            S_SETUP:
            begin
                r1_reg <= r1_mem[i_reg];
                r2_reg <= 64'(r2_mem[i_reg]);
                p1_reg <= 64'(p1_mem[i_reg]);
                p2_reg <= txs_reg - (r1_mem[i_reg] + pss_reg);
            end
            // Low halves of both products
            S_MUL1:
            begin
                m1_reg <= {32'd0, r1_reg[31:0]} * {32'd0, r2_reg[31:0]};
                m2_reg <= {32'd0, p1_reg[31:0]} * {32'd0, p2_reg[31:0]};
            end
            // Add the upper cross terms, modulo 2^64
            S_MUL2:
            begin
                m1_reg <= m1_reg + {r1_reg[63:32] * r2_reg[31:0], 32'd0};
                m2_reg <= m2_reg + {p2_reg[63:32] * p1_reg[31:0], 32'd0};
            end
            S_DEN:
                den_reg <= r1_reg + r2_reg + p1_reg + p2_reg;
            default:
                ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> ov_reg)
        else $error("result dropped under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_busy)
        else $error("divider did not start");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAITDIV) |-> (div_busy || div_done))
        else $error("waiting on idle divider");
endmodule

// File: dv/testbench.sv
// Testbench for ds_twr_multi_initiator_core: directed table, then random ranging rounds.
// Depends on rtl/dtwr_pkg.sv and rtl/ds_twr_multi_initiator_core.sv.
`timescale 1ns / 1ps
module testbench;
    import dtwr_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int HOLD_CYCLES = 700;
    localparam int RANDOM_ITEMS = 116;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ds_twr_multi_initiator_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Mirror of the ranging state
    logic [7:0]  slot_id [RESPONDER_COUNT];
    logic [39:0] reply_delay;
    logic        in_ack_phase;
    logic        in_final_phase;
    logic [2:0]  slot_cnt;
    logic [7:0]  seq_num;
    logic [63:0] poll_stamp;
    logic [63:0] round1 [RESPONDER_COUNT];
    logic [31:0] reply1 [RESPONDER_COUNT];
    logic [31:0] round2 [RESPONDER_COUNT];

    out_item_t pending_results[$];
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int rounds_done = 0;
    int idle_cycles = 0;
    bit bursts_on = 1;
    bit hold_req = 0;
    bit typed_row = 0;

    // Directed stimulus table; typed rows carry their expected results
    typedef struct {
        in_item_t  item;
        bit        typed;
        int        n_exp;
        out_item_t exp0;
        out_item_t exp1;
    } dir_row_t;
    dir_row_t dir_rows[$];

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic out_item_t make_result(action_t act, logic [7:0] seq,
        logic [31:0] when, logic [2:0] slot, logic [63:0] ticks, logic ok, logic last);
        out_item_t r;
        r.action = act;
        r.sequence_number = seq;
        r.delayed_send_time = when;
        r.responder_slot = slot;
        r.flight_ticks = ticks;
        r.flight_valid = ok;
        r.last_result = last;
        return r;
    endfunction

    // Advance the ranging state for one reception and queue its results
    task automatic predict_ranging(in_item_t it, bit push);
        out_item_t res[$];
        logic [63:0] rx, tx, r1, r2, p1, p2, num, den, q;
        logic [63:0] sum;
        int c;
        rx = {24'd0, it.receive_stamp};
        tx = {24'd0, it.transmit_stamp};
        if (!in_ack_phase && !in_final_phase && slot_cnt == 0)
        begin
            in_ack_phase = 1;
            res.push_back(make_result(ACT_POLL, seq_num, 0, 0, 0, 0, 0));
        end
        else
            res.push_back(make_result(ACT_LISTEN, 0, 0, 0, 0, 0, 0));
        c = slot_cnt;
        if (!it.frame_good)
        begin
            res.push_back(make_result(ACT_RESET, seq_num, 0, 0, 0, 0, 0));
            in_ack_phase = 0; in_final_phase = 0; slot_cnt = 0;
        end
        else if (c >= RESPONDER_COUNT || it.source_id != slot_id[c])
        begin
            in_ack_phase = 0; in_final_phase = 0; slot_cnt = 0;
        end
        else
        begin
            if (in_ack_phase)
            begin
                poll_stamp = tx;
                round1[c] = rx - poll_stamp;
                reply1[c] = it.carried_reply_time;
            end
            else
                round2[c] = it.carried_reply_time;
            slot_cnt = 3'(c + 1);
            if (in_ack_phase && slot_cnt == RESPONDER_COUNT)
            begin
                sum = rx + {24'd0, reply_delay};
                res.push_back(make_result(ACT_RANGE, seq_num, sum[39:8], 0, 0, 0, 0));
                in_ack_phase = 0; in_final_phase = 1; slot_cnt = 0;
            end
            else if (in_final_phase && slot_cnt == RESPONDER_COUNT)
            begin
                for (int i = 0; i < RESPONDER_COUNT; i++)
                begin
                    r1 = round1[i];
                    r2 = {32'd0, round2[i]};
                    p1 = {32'd0, reply1[i]};
                    p2 = tx - (r1 + poll_stamp);
                    num = r1 * r2 - p1 * p2;
                    den = r1 + r2 + p1 + p2;
                    q = (den != 0) ? num / den : 64'd0;
                    res.push_back(make_result(ACT_RESULT, seq_num, 0, 3'(i), q, den != 0, 0));
                end
                in_ack_phase = 0; in_final_phase = 0; slot_cnt = 0;
                seq_num = seq_num + 1;
                rounds_done++;
            end
        end
        res[res.size() - 1].last_result = 1;
        if (push)
            foreach (res[k]) pending_results.push_back(res[k]);
    endtask

    task automatic write_reg(int idx, logic [39:0] value);
        @(negedge clk);
        cfg_we = 1;
        cfg_index = CFG_IDX_W'(idx);
        cfg_data = value;
        if (idx < RESPONDER_COUNT)
            slot_id[idx] = value[7:0];
        else if (idx == CFG_DELAY_IDX)
            reply_delay = value;
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // Offer one transaction; valid stays high until it is taken
    task automatic send_item(in_item_t it);
        int gap;
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_valid = 0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1;
        in_data = it;
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        predict_ranging(it, !typed_row);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic in_item_t random_item();
        in_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        it.frame_good = (pick >= 6);
        it.source_id = (pick < 86 && slot_cnt < RESPONDER_COUNT) ?
            slot_id[slot_cnt] : 8'($urandom_range(0, 255));
        it.carried_reply_time = $urandom;
        it.receive_stamp = {8'($urandom_range(0, 255)), $urandom};
        it.transmit_stamp = $urandom_range(0, 1) ? {8'($urandom_range(0, 255)), $urandom} :
            it.receive_stamp - 40'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic in_item_t make_item(logic good, logic [7:0] sid, logic [31:0] carried,
        logic [39:0] rx, logic [39:0] tx);
        in_item_t it;
        it.frame_good = good;
        it.source_id = sid;
        it.carried_reply_time = carried;
        it.receive_stamp = rx;
        it.transmit_stamp = tx;
        return it;
    endfunction

    task automatic add_row(in_item_t it, bit typed, int n, out_item_t e0, out_item_t e1);
        dir_row_t row;
        row.item = it; row.typed = typed; row.n_exp = n; row.exp0 = e0; row.exp1 = e1;
        dir_rows.push_back(row);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int hold_count;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(negedge clk);
                hold_req = 0;
                out_ready = 1;
            end
            else if (bursts_on && $urandom_range(0, 7) == 0)
            begin
                out_ready = 0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                out_ready = 1;
            end
            else
                out_ready = 1;
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        out_item_t exp;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none actual %h", $time, out_data);
            end
            else
            begin
                exp = pending_results.pop_front();
                if (out_data.action !== exp.action)
                    $display("%0t action: expected %0d actual %0d", $time, exp.action,
                        out_data.action);
                if (out_data.sequence_number !== exp.sequence_number)
                    $display("%0t sequence_number: expected %h actual %h", $time,
                        exp.sequence_number, out_data.sequence_number);
                if (out_data.delayed_send_time !== exp.delayed_send_time)
                    $display("%0t delayed_send_time: expected %h actual %h", $time,
                        exp.delayed_send_time, out_data.delayed_send_time);
                if (out_data.responder_slot !== exp.responder_slot)
                    $display("%0t responder_slot: expected %0d actual %0d", $time,
                        exp.responder_slot, out_data.responder_slot);
                if (out_data.flight_ticks !== exp.flight_ticks)
                    $display("%0t flight_ticks: expected %h actual %h", $time,
                        exp.flight_ticks, out_data.flight_ticks);
                if (out_data.flight_valid !== exp.flight_valid)
                    $display("%0t flight_valid: expected %b actual %b", $time,
                        exp.flight_valid, out_data.flight_valid);
                if (out_data.last_result !== exp.last_result)
                    $display("%0t last_result: expected %b actual %b", $time,
                        exp.last_result, out_data.last_result);
                if (out_data !== exp)
                    errors++;
            end
        end
    end

    // Watchdog: count cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        logic [39:0] top;
        out_item_t none;
        none = '0;
        top = 40'hFF_FFFF_FFFF;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        foreach (slot_id[i]) slot_id[i] = 0;
        reply_delay = 0;
        in_ack_phase = 1;
        in_final_phase = 0;
        slot_cnt = 0;
        seq_num = 0;
        poll_stamp = 0;
        foreach (round1[i])
        begin
            round1[i] = 0; reply1[i] = 0; round2[i] = 0;
        end
        repeat (11) @(negedge clk);
        rst_n = 1;

        // Directed: extreme ids and the largest turnaround delay
        write_reg(0, 40'h00);
        write_reg(1, 40'hFF);
        write_reg(2, 40'h5A);
        write_reg(3, 40'hA5);
        write_reg(4, 40'h3C);
        write_reg(CFG_DELAY_IDX, top);

        // Timeout straight after reset, wrong id, timeout after a poll
        add_row(make_item(0, 8'h00, 0, 0, 0), 1, 2,
            make_result(ACT_LISTEN, 0, 0, 0, 0, 0, 0),
            make_result(ACT_RESET, 0, 0, 0, 0, 0, 1));
        add_row(make_item(1, 8'h01, 32'hFFFF_FFFF, top, top), 1, 1,
            make_result(ACT_POLL, 0, 0, 0, 0, 0, 1), none);
        add_row(make_item(0, 8'hFF, 0, top, 0), 1, 2,
            make_result(ACT_POLL, 0, 0, 0, 0, 0, 0),
            make_result(ACT_RESET, 0, 0, 0, 0, 0, 1));
        // Zero round and reply times: every denominator is zero
        for (int i = 0; i < 5; i++)
            add_row(make_item(1, slot_id[i], 0, top, top), 0, 0, none, none);
        for (int i = 0; i < 5; i++)
            add_row(make_item(1, slot_id[i], 0, 0, top), 0, 0, none, none);
        // Extreme carried times and stamps
        for (int i = 0; i < 5; i++)
            add_row(make_item(1, slot_id[i], 32'hFFFF_FFFF, (i == 4) ? top : 40'(i * 1000), 0),
                0, 0, none, none);
        for (int i = 0; i < 5; i++)
            add_row(make_item(1, slot_id[i], (i == 0) ? 32'hFFFF_FFFF : 32'(1234 * i), 0,
                (i == 4) ? top : 40'd0), 0, 0, none, none);

        foreach (dir_rows[r])
        begin
            typed_row = dir_rows[r].typed;
            if (typed_row)
            begin
                pending_results.push_back(dir_rows[r].exp0);
                if (dir_rows[r].n_exp > 1)
                    pending_results.push_back(dir_rows[r].exp1);
            end
            send_item(dir_rows[r].item);
            typed_row = 0;
        end
        in_valid = 0;
        wait_drained();

        // Random phases under different settings; the last one runs without idling
        for (int ph = 0; ph < 3; ph++)
        begin
            for (int i = 0; i < RESPONDER_COUNT; i++)
                write_reg(i, (ph == 1) ? 40'd0 : 40'($urandom_range(0, 255)));
            write_reg(CFG_DELAY_IDX,
                (ph == 1) ? 40'd0 : {8'($urandom_range(0, 255)), $urandom});
            if (ph == 0)
                hold_req = 1;
            if (ph == 2)
                bursts_on = 0;
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                if (ph == 1 && n == RANDOM_ITEMS / 2)
                begin
                    in_valid = 0;
                    while (pending_results.size() != 0)
                        @(negedge clk);
                end
                send_item(random_item());
            end
            in_valid = 0;
            wait_drained();
        end

        repeat (400) @(negedge clk);
        $display("Covered %0d receptions, %0d result transactions, %0d completed rounds,",
            items_sent, results_seen, rounds_done);
        $display("across four register settings with stalls on both channels.");
        if (errors == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: ds_twr_multi_initiator_core.f
rtl/dtwr_pkg.sv
rtl/dtwr_front.sv
rtl/dtwr_fifo.sv
rtl/dtwr_div.sv
rtl/dtwr_back.sv
rtl/ds_twr_multi_initiator_core.sv
dv/testbench.sv
